/* hw/rtl/bdasc_pkg.sv */
// ----------------------------------------------------------------------------
// bdasc_pkg
// Shared constants and types for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package bdasc_pkg;

    // width of the binary input value (4 to 64)
    localparam int VALUE_BITS = 32;

    // decimal digits needed for VALUE_BITS: floor(bits * log10(2)) + 1
    localparam int LOG10_2_Q12 = 1233;
    localparam int DIGITS      = ((VALUE_BITS * LOG10_2_Q12) >> 12) + 1;
    localparam int BCD_BITS    = 4 * DIGITS;

    localparam int STEP_W = $clog2(VALUE_BITS + 1);
    localparam int DIG_W  = $clog2(DIGITS + 1);

    localparam int CHAR_BITS = 6;
    localparam int S_DATA_W  = 8 * ((VALUE_BITS + 7) / 8);
    localparam int M_DATA_W  = 8 * ((CHAR_BITS + 7) / 8);

    localparam logic [CHAR_BITS-1:0] ASCII_ZERO = 6'd48;

    // double dabble correction: nibbles at or above the threshold get the offset
    localparam logic [3:0] DD_THRESH = 4'd5;
    localparam logic [3:0] DD_OFFSET = 4'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic skip;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic step_last;
        logic top_zero;
        logic last_digit;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/binary_to_decimal_ascii_core.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core
// Converts an unsigned binary value to a stream of ascii decimal digits.
// ----------------------------------------------------------------------------
// One request on the slave side carries a VALUE_BITS-bit unsigned number; the
// master side then delivers its decimal digits as ascii characters, most
// significant first, with no leading zeros ('0' alone for zero) and tlast on
// the final digit. A value passes through a load, the double dabble
// shift-add-3 steps (one bit per cycle through a single shifter), a skip of
// each leading zero, a hand-off and the emission of each digit. The
// output register lets the next value be accepted while the final digit
// still waits.
module binary_to_decimal_ascii_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [bdasc_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] value
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [bdasc_pkg::M_DATA_W-1:0] m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                           m_tlast
);

    bdasc_pkg::dp_cmd_t    cmd;
    bdasc_pkg::dp_status_t status;

    bdasc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bdasc_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* hw/rtl/bdasc_ctrl.sv */
// ----------------------------------------------------------------------------
// bdasc_ctrl
// Sequencer: load, shift-add-3 steps, leading zero skip, digit emission.
// ----------------------------------------------------------------------------
module bdasc_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  bdasc_pkg::dp_status_t status,
    output bdasc_pkg::dp_cmd_t    cmd
);

    typedef enum logic [3:0]
    {
        ST_IDLE    = 4'b0001,
        ST_CONVERT = 4'b0010,
        ST_SKIP    = 4'b0100,
        ST_EMIT    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.step = 1'b1;
                if (status.step_last)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                // drop leading zeros but always keep the final digit
                if (status.top_zero && !status.last_digit)
                begin
                    cmd.skip = 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.last_digit)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/bdasc_datapath.sv */
// ----------------------------------------------------------------------------
// bdasc_datapath
// Double dabble shift register, digit counter and output register.
// ----------------------------------------------------------------------------
module bdasc_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bdasc_pkg::S_DATA_W-1:0]      s_tdata,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [bdasc_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    input  bdasc_pkg::dp_cmd_t                  cmd,
    output bdasc_pkg::dp_status_t               status
);

    logic [bdasc_pkg::VALUE_BITS-1:0] bin_reg;
    logic [bdasc_pkg::BCD_BITS-1:0]   bcd_reg;
    logic [bdasc_pkg::BCD_BITS-1:0]   bcd_adj;
    logic [bdasc_pkg::STEP_W-1:0]     step_reg;
    logic [bdasc_pkg::DIG_W-1:0]      digit_reg;
    logic [bdasc_pkg::CHAR_BITS-1:0]  out_char_reg;
    logic                             out_last_reg;
    logic                             out_valid_reg;
    logic [3:0]                       top_nib;

    assign top_nib = bcd_reg[bdasc_pkg::BCD_BITS-1 -: 4];

    // add 3 to every nibble of 5 or more before the shift
    always_comb
    begin
        logic [3:0] nib;
        nib = '0;
        for (int i = 0; i < bdasc_pkg::DIGITS; i++)
        begin
            nib = bcd_reg[4*i +: 4];
            bcd_adj[4*i +: 4] = (nib >= bdasc_pkg::DD_THRESH) ? nib + bdasc_pkg::DD_OFFSET
                                                              : nib;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            bin_reg   <= s_tdata[bdasc_pkg::VALUE_BITS-1:0];
            bcd_reg   <= '0;
            step_reg  <= bdasc_pkg::STEP_W'(bdasc_pkg::VALUE_BITS);
            digit_reg <= bdasc_pkg::DIG_W'(bdasc_pkg::DIGITS);
        end
        else if (cmd.step)
        begin
            bcd_reg  <= {bcd_adj[bdasc_pkg::BCD_BITS-2:0],
                         bin_reg[bdasc_pkg::VALUE_BITS-1]};
            bin_reg  <= {bin_reg[bdasc_pkg::VALUE_BITS-2:0], 1'b0};
            step_reg <= step_reg - 1'b1;
        end
        else if (cmd.skip || cmd.emit)
        begin
            bcd_reg   <= {bcd_reg[bdasc_pkg::BCD_BITS-5:0], 4'h0};
            digit_reg <= digit_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_char_reg <= {2'b00, top_nib} + bdasc_pkg::ASCII_ZERO;
            out_last_reg <= (digit_reg == bdasc_pkg::DIG_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.step_last  = (step_reg == bdasc_pkg::STEP_W'(1));
    assign status.top_zero   = (top_nib == 4'h0);
    assign status.last_digit = (digit_reg == bdasc_pkg::DIG_W'(1));
    assign status.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(bdasc_pkg::M_DATA_W - bdasc_pkg::CHAR_BITS)'(0), out_char_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/bdasc_checker.sv */
// ----------------------------------------------------------------------------
// bdasc_checker
// Port level checks for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
module bdasc_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bdasc_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bdasc_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast
);

    // a stalled digit holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    // only decimal digit characters leave the block
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata >= bdasc_pkg::M_DATA_W'(48)) &&
                     (m_tdata <= bdasc_pkg::M_DATA_W'(57)))
        else $error("output character is not a decimal digit");

    // conversion is busy right after a value is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // no new value while a number is still mid-stream
    a_no_accept_mid_number: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input ready before the final digit was produced");

endmodule

bind binary_to_decimal_ascii_core bdasc_checker u_bdasc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

/* sim/binary_to_decimal_ascii_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_core_test
// Self-checking bench for the binary to decimal ascii converter.
// A table of directed values runs first, then random values biased toward
// decimal digit boundaries. Each accepted request queues its expected digit
// characters, and the digit stream on the master side is checked against
// them in order. Both sides idle in random bursts. The sink also holds off
// once for a long stretch so that the core backs up its input.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_core_test;

    localparam int RANDOM_COUNT = 140;
    localparam int QUIET_COUNT  = 30;
    localparam int SINK_HOLD    = 400;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_DIGITS   = 20;

    typedef struct packed {
        logic [bdasc_pkg::CHAR_BITS-1:0] digit_char;
        logic                            last;
    } digit_t;

    typedef struct {
        logic [bdasc_pkg::S_DATA_W-1:0] value;
        string                          text;   // empty: use the predictor
    } directed_row_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [bdasc_pkg::S_DATA_W-1:0] s_tdata;    // [31:0] value
    logic                           m_tvalid;
    logic                           m_tready;
    logic [bdasc_pkg::M_DATA_W-1:0] m_tdata;    // [5:0] digit_char, [7:6] zero
    logic                           m_tlast;

    digit_t digit_queue[$];
    digit_t want_digit;
    int     error_count = 0;
    int     cycle_count = 0;
    bit     quiet_mode = 1'b0;
    bit     sink_hold_req = 1'b0;
    bit     sink_hold_done = 1'b0;
    int     sink_stall_left = 0;
    int     sink_hold_left = 0;

    directed_row_t directed_rows [20] = '{
        '{32'd0,          "0"},
        '{32'd1,          "1"},
        '{32'd9,          "9"},
        '{32'd10,         "10"},
        '{32'd99,         ""},
        '{32'd100,        ""},
        '{32'd999999999,  "999999999"},
        '{32'd1000000000, "1000000000"},
        '{32'hFFFFFFFF,   "4294967295"},
        '{32'hFFFFFFFE,   ""},
        '{32'h80000000,   ""},
        '{32'h7FFFFFFF,   ""},
        '{32'h55555555,   ""},
        '{32'hAAAAAAAA,   ""},
        '{32'h0000FFFF,   ""},
        '{32'hFFFF0000,   ""},
        '{32'd4000000000, "4000000000"},
        '{32'd12345,      ""},
        '{32'd1023,       ""},
        '{32'd65536,      ""}
    };

    binary_to_decimal_ascii_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // decimal digits of one value, most significant first, last flag on the final one
    function automatic void queue_decimal_digits(input logic [bdasc_pkg::S_DATA_W-1:0] val);
        logic [63:0] rest;
        logic [3:0]  dec [MAX_DIGITS];
        int          n;
        rest = 64'(val);
        if (bdasc_pkg::VALUE_BITS < 64)
            rest = rest & ((64'd1 << bdasc_pkg::VALUE_BITS) - 64'd1);
        n = 0;
        do
        begin
            dec[n] = 4'(rest % 64'd10);
            rest   = rest / 64'd10;
            n++;
        end
        while (rest != 64'd0 && n < MAX_DIGITS);
        for (int k = n - 1; k >= 0; k--)
            digit_queue.push_back('{digit_char: bdasc_pkg::ASCII_ZERO +
                                                bdasc_pkg::CHAR_BITS'(dec[k]),
                                    last: (k == 0)});
    endfunction

    function automatic void queue_digit_text(input string text);
        for (int i = 0; i < text.len(); i++)
            digit_queue.push_back('{digit_char: bdasc_pkg::CHAR_BITS'(text[i]),
                                    last: (i == text.len() - 1)});
    endfunction

    // called at a falling edge, returns at a falling edge after the request is taken
    task automatic send_value(input logic [bdasc_pkg::S_DATA_W-1:0] val, input string text);
        int gap;
        if (!quiet_mode && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom();
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
        if (text.len() == 0)
            queue_decimal_digits(val);
        else
            queue_digit_text(text);
        @(negedge clk);
    endtask

    function automatic logic [bdasc_pkg::S_DATA_W-1:0] random_value();
        logic [63:0] pow;
        int          p;
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $urandom() >> $urandom_range(0, 31);
            2:
            begin
                // land on either side of a power of ten
                p   = $urandom_range(0, 9);
                pow = 64'd1;
                repeat (p) pow = pow * 64'd10;
                return bdasc_pkg::S_DATA_W'(pow + 64'($urandom_range(0, 2)) - 64'd1);
            end
            default: return bdasc_pkg::S_DATA_W'($urandom_range(0, 999));
        endcase
    endfunction

    // sink: random stall bursts, one long hold-off on request, none when quiet
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin : sink_ready
            logic ready_next;
            @(negedge clk);
            if (sink_hold_req && !sink_hold_done)
            begin
                sink_hold_done = 1'b1;
                sink_hold_left = SINK_HOLD;
            end
            if (sink_hold_left > 0)
            begin
                sink_hold_left--;
                ready_next = 1'b0;
            end
            else if (quiet_mode)
            begin
                ready_next = 1'b1;
            end
            else if (sink_stall_left > 0)
            begin
                sink_stall_left--;
                ready_next = 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                sink_stall_left = $urandom_range(1, 7) - 1;
                ready_next = 1'b0;
            end
            else
            begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (digit_queue.size() == 0)
            begin
                $display("%0t: unexpected digit, expected none, actual char %0d last %0b",
                         $realtime, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want_digit = digit_queue.pop_front();
                if (m_tdata != bdasc_pkg::M_DATA_W'(want_digit.digit_char))
                begin
                    $display("%0t: digit_char mismatch, expected %0d actual %0d",
                             $realtime, want_digit.digit_char, m_tdata);
                    error_count++;
                end
                if (m_tlast != want_digit.last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $realtime, want_digit.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout, %0d digits still expected",
                     $realtime, digit_queue.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_value(directed_rows[i].value, directed_rows[i].text);

        // sink stops for a while as random traffic begins, so the core backs up
        sink_hold_req = 1'b1;
        for (int i = 0; i < RANDOM_COUNT; i++)
        begin
            if (i == RANDOM_COUNT - QUIET_COUNT)
                quiet_mode = 1'b1;
            send_value(random_value(), "");
        end
        s_tvalid <= 1'b0;

        while (digit_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
